### rtl/table_driven_prefix_code_packer_defines.svh
// Assertion macros for the prefix code packer.
`ifndef TABLE_DRIVEN_PREFIX_CODE_PACKER_DEFINES_SVH
`define TABLE_DRIVEN_PREFIX_CODE_PACKER_DEFINES_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packer check failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packer check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/tdpc_pkg.sv
// Shared types and constants of the prefix code packer.
package tdpc_pkg;

   localparam int CMD_W     = 2;
   localparam int SYM_W     = 8;
   localparam int CODE_W    = 16;
   localparam int LEN_FLD_W = 5;
   localparam int BYTE_W    = 8;
   localparam int PEND_W    = 7;
   // bit count of the accumulator: up to 7 pending plus 16 code bits
   localparam int CNT_W     = 5;
   // most bytes one encode can complete
   localparam int OUT_DEPTH = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic              last;
      logic [BYTE_W-1:0] packed_byte;
   } out_entry_type;

endpackage

### rtl/tdpc_channels.sv
// Request and response channel interfaces of the prefix code packer.
interface tdpc_req_if;
   import tdpc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [SYM_W-1:0]     symbol;
   logic [CODE_W-1:0]    code_bits;
   logic [LEN_FLD_W-1:0] code_length;

   modport source (output valid, command, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, command, symbol, code_bits, code_length, output ready);
endinterface

interface tdpc_rsp_if;
   import tdpc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] packed_byte;
   logic              last;

   modport source (output valid, packed_byte, last, input ready);
   modport sink   (input valid, packed_byte, last, output ready);
endinterface

### rtl/table_driven_prefix_code_packer.sv
// Top level of the table-driven prefix code (Huffman) bit packer.
//
// The block takes one request per cycle: a load writes one code table entry,
// an encode appends its symbol's code to the bit accumulator, a flush emits
// the partial byte right-aligned and marked last. The code table is a
// memory with one write and one registered read port; it is read in the
// cycle a request is taken and the accumulator works on the read data in
// the next cycle, and the bytes it cuts leave from the registered output buffer.
// Loads land in request order, so an encode right after a load of the same
// symbol sees the new code. Each response transfer moves one byte and a
// two-entry output buffer holds finished bytes. A new request is taken every
// cycle as long as the bytes of the request ahead fit beside what the buffer
// already holds; a byte leaving in the same cycle frees its slot only from
// the next cycle on. So an encode that completes two bytes waits for an
// empty buffer, and a steady run of one-byte encodes needs a consumer that
// is ready every cycle. Loads and encodes that complete no byte never stall.
// Per-entry valid flops clear the table at reset.
module table_driven_prefix_code_packer #(
   parameter int MAX_CODE_LEN = 16,
   parameter int SYMBOLS      = 256
) (
   input  logic       clock,
   input  logic       reset,
   tdpc_req_if.sink   req_ch,
   tdpc_rsp_if.source rsp_ch
);
   import tdpc_pkg::*;

`include "table_driven_prefix_code_packer_defines.svh"

   localparam int LEN_LIM = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
   localparam int LEN_W   = $clog2(LEN_LIM + 1);
   localparam int SYM_AW  = $clog2(SYMBOLS);
   localparam int MEM_W   = LEN_W + LEN_LIM;
   localparam int ACC_W   = PEND_W + LEN_LIM;

   // code table storage
   logic [MEM_W-1:0]   code_mem [SYMBOLS];
   logic [SYMBOLS-1:0] entry_valid_ff;
   logic [MEM_W-1:0]   rd_data_ff;
   logic               rd_valid_ff;

   // stage 1 registers
   logic               s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]   s1_cmd_ff;
   logic               s1_in_range_ff;

   // accumulator
   logic [PEND_W-1:0]  pend_bits_ff, pend_bits_in;
   logic [2:0]         pend_count_ff, pend_count_in;

   // output buffer
   out_entry_type      out_q_ff [OUT_DEPTH];
   out_entry_type      out_q_in [OUT_DEPTH];
   logic [1:0]         out_count_ff, out_count_in;

   logic               req_fire;
   logic               rsp_fire;
   logic               in_range;
   logic [SYM_AW-1:0]  addr;
   logic [LEN_FLD_W-1:0] len_sat;
   logic [CODE_W-1:0]  code_masked;
   logic [MEM_W-1:0]   wr_data;

   logic [LEN_W-1:0]   ent_len;
   logic [LEN_LIM-1:0] ent_code;
   logic [ACC_W-1:0]   acc;
   logic [CNT_W-1:0]   cnt;
   logic [1:0]         emit_n;
   out_entry_type      emit_ent [OUT_DEPTH];
   logic               s1_advance;

   // request decode
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign in_range = {1'b0, req_ch.symbol} < (SYM_W + 1)'(SYMBOLS);
   assign addr     = req_ch.symbol[SYM_AW-1:0];
   assign len_sat  = (req_ch.code_length > LEN_FLD_W'(LEN_LIM)) ?
                     LEN_FLD_W'(LEN_LIM) : req_ch.code_length;
   assign code_masked = req_ch.code_bits &
                        CODE_W'(((CODE_W + 1)'(1) << len_sat) - (CODE_W + 1)'(1));
   assign wr_data  = {LEN_W'(len_sat), code_masked[LEN_LIM-1:0]};

   // table write and registered read
   always_ff @(posedge clock) begin
      if (req_fire && req_ch.command == CMD_LOAD && in_range) begin
         code_mem[addr] <= wr_data;
      end
      if (req_fire) begin
         rd_data_ff <= code_mem[addr];
      end
   end

   // per-entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (req_fire && req_ch.command == CMD_LOAD && in_range) begin
         entry_valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_valid_ff    <= entry_valid_ff[addr];
         s1_cmd_ff      <= req_ch.command;
         s1_in_range_ff <= in_range;
      end
   end

   // stage 1: accumulate and cut bytes
   always_comb begin
      ent_len  = '0;
      ent_code = '0;
      if (s1_in_range_ff && rd_valid_ff) begin
         ent_len  = rd_data_ff[MEM_W-1 -: LEN_W];
         ent_code = rd_data_ff[LEN_LIM-1:0];
      end
      acc = (ACC_W'(pend_bits_ff) << ent_len) | ACC_W'(ent_code);
      cnt = CNT_W'(pend_count_ff) + CNT_W'(ent_len);
      emit_n        = '0;
      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      for (int k = 0; k < OUT_DEPTH; k++) begin
         emit_ent[k].last        = 1'b0;
         emit_ent[k].packed_byte = BYTE_W'(acc >> (cnt - CNT_W'(BYTE_W * (k + 1))));
      end
      case (s1_cmd_ff)
         CMD_ENCODE: begin
            if (ent_len != '0) begin
               emit_n        = 2'(cnt >> 3);
               pend_count_in = cnt[2:0];
               pend_bits_in  = PEND_W'(acc) &
                               PEND_W'((8'd1 << cnt[2:0]) - 8'd1);
            end
         end
         CMD_FLUSH: begin
            emit_ent[0].last        = 1'b1;
            emit_ent[0].packed_byte = BYTE_W'(pend_bits_ff);
            emit_n        = (pend_count_ff != '0) ? 2'd1 : 2'd0;
            pend_count_in = '0;
            pend_bits_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // stage 1 moves on when its bytes fit in the output buffer
   assign s1_advance   = s1_valid_ff &&
                         ({1'b0, out_count_ff} + {1'b0, emit_n} <= 3'(OUT_DEPTH));
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_advance) begin
            pend_bits_ff  <= pend_bits_in;
            pend_count_ff <= pend_count_in;
         end
      end
   end

   // output buffer: pop head, then append new bytes behind what remains
   always_comb begin
      logic [1:0] kept;
      logic [1:0] push_n;
      logic [1:0] slot;
      kept   = out_count_ff - {1'b0, rsp_fire};
      push_n = s1_advance ? emit_n : 2'd0;
      for (int i = 0; i < OUT_DEPTH; i++) begin
         if (rsp_fire && i + 1 < OUT_DEPTH) begin
            out_q_in[i] = out_q_ff[i + 1];
         end else begin
            out_q_in[i] = out_q_ff[i];
         end
         slot = 2'(i) - kept;
         if (2'(i) >= kept && slot < push_n) begin
            out_q_in[i] = emit_ent[slot[0]];
         end
      end
      out_count_in = kept + push_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff <= '0;
      end else begin
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      out_q_ff <= out_q_in;
   end

   assign rsp_ch.valid       = out_count_ff != '0;
   assign rsp_ch.packed_byte = out_q_ff[0].packed_byte;
   assign rsp_ch.last        = out_q_ff[0].last;

   // checks
   `ASSERT_IMPLIES(a_out_count_bound, clock, reset, 1'b1, out_count_ff <= 2'(OUT_DEPTH))
   `ASSERT_IMPLIES(a_stall_only_on_emit, clock, reset, s1_valid_ff && !s1_advance, emit_n != 2'd0)
   `ASSERT_NEXT(a_flush_clears, clock, reset, s1_advance && s1_cmd_ff == CMD_FLUSH, pend_count_ff == 3'd0)
   `ASSERT_IMPLIES(a_pending_fits, clock, reset, 1'b1, (pend_bits_ff >> pend_count_ff) == '0)

endmodule

### bench/table_driven_prefix_code_packer_tb.sv
// Self-checking testbench for the table-driven prefix code packer.
module table_driven_prefix_code_packer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdpc_pkg::*;

   // command 3 has no meaning; the block drops it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // stored lengths saturate at the smaller of MAX_CODE_LEN and the code bits field width
   localparam int CODE_LEN_CAP = 16;
   localparam int N_DIRECTED   = 25;
   localparam int N_RANDOM     = 185;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 12;
   localparam int LIMIT_NS     = 400_000;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [SYM_W-1:0]     symbol;
      logic [CODE_W-1:0]    code_bits;
      logic [LEN_FLD_W-1:0] code_length;
   } req_type;

   // one stimulus row; typed rows carry their expected bytes
   typedef struct packed {
      req_type       rq;
      logic          typed;
      logic [1:0]    n_typed;
      out_entry_type exp0;
      out_entry_type exp1;
   } stim_row_type;

   logic clock;
   logic reset;

   tdpc_req_if req_ch ();
   tdpc_rsp_if rsp_ch ();

   table_driven_prefix_code_packer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow of the code table and the bit accumulator
   logic [CODE_W-1:0]    code_tab [256];
   logic [LEN_FLD_W-1:0] len_tab  [256];
   logic [PEND_W-1:0]    acc_bits;
   logic [2:0]           acc_cnt;

   out_entry_type due_bytes [$];

   int  mismatches  = 0;
   int  bytes_seen  = 0;
   int  tails_seen  = 0;
   int  n_loads     = 0;
   int  n_encodes   = 0;
   int  n_flushes   = 0;
   int  n_unused    = 0;
   bit  hold_req    = 1'b0;
   bit  no_idle     = 1'b0;
   int  held_cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #(LIMIT_NS);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report_mismatch(input string field, input logic [8:0] got,
                                  input logic [8:0] want);
      $display("%0t ns byte %0d: %s got %h, expected %h", $time, bytes_seen, field,
               got, want);
      mismatches++;
   endtask

   // Bytes that one accepted request completes; advances the shadow state.
   function automatic int pack_request(input req_type rq, output out_entry_type done [2]);
      logic [31:0] acc;
      int unsigned clen;
      int unsigned cnt;
      int          n;
      n = 0;
      done[0] = '0;
      done[1] = '0;
      case (rq.command)
         CMD_LOAD: begin
            clen = (rq.code_length > CODE_LEN_CAP) ? CODE_LEN_CAP : rq.code_length;
            len_tab[rq.symbol]  = LEN_FLD_W'(clen);
            // bits above the stored length are dropped
            code_tab[rq.symbol] = CODE_W'(32'(rq.code_bits) & ((32'd1 << clen) - 32'd1));
         end
         CMD_ENCODE: begin
            clen = len_tab[rq.symbol];
            // zero-length symbols leave the accumulator alone
            if (clen != 0) begin
               acc = (32'(acc_bits) << clen) | 32'(code_tab[rq.symbol]);
               cnt = acc_cnt + clen;
               while (cnt >= 8) begin
                  done[n].last        = 1'b0;
                  done[n].packed_byte = 8'(acc >> (cnt - 8));
                  n++;
                  cnt -= 8;
               end
               acc_cnt  = 3'(cnt);
               acc_bits = PEND_W'(acc & ((32'd1 << cnt) - 32'd1));
            end
         end
         CMD_FLUSH: begin
            // partial byte goes out right-aligned; an empty flush sends nothing
            if (acc_cnt != 0) begin
               done[0].last        = 1'b1;
               done[0].packed_byte = {1'b0, acc_bits};
               n = 1;
            end
            acc_bits = '0;
            acc_cnt  = '0;
         end
         default: ;
      endcase
      return n;
   endfunction

   // Offer one request after a random gap, wait for the transfer, queue what is due.
   task automatic send_request(input stim_row_type row);
      out_entry_type done [2];
      int            n;
      int            gap;
      gap = (no_idle || hold_req) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= row.rq.command;
      req_ch.symbol      <= row.rq.symbol;
      req_ch.code_bits   <= row.rq.code_bits;
      req_ch.code_length <= row.rq.code_length;
      do @(posedge clock); while (!req_ch.ready);
      n = pack_request(row.rq, done);
      if (row.typed) begin
         n       = row.n_typed;
         done[0] = row.exp0;
         done[1] = row.exp1;
      end
      for (int k = 0; k < n; k++) due_bytes.insert(due_bytes.size(), done[k]);
      case (row.rq.command)
         CMD_LOAD:   n_loads++;
         CMD_ENCODE: n_encodes++;
         CMD_FLUSH:  n_flushes++;
         default:    n_unused++;
      endcase
   endtask

   // Directed rows: extremes and the special cases, from reset.
   function automatic stim_row_type directed_row(input int i);
      case (i)
         // encode against the cleared table
         0:  return '{'{CMD_ENCODE, 8'h00, 16'h0000, 5'd0},  1'b1, 2'd0, 9'h000, 9'h000};
         // flush with nothing pending
         1:  return '{'{CMD_FLUSH,  8'h00, 16'h0000, 5'd0},  1'b1, 2'd0, 9'h000, 9'h000};
         2:  return '{'{CMD_UNUSED, 8'h41, 16'hFFFF, 5'd16}, 1'b1, 2'd0, 9'h000, 9'h000};
         3:  return '{'{CMD_LOAD,   8'h41, 16'hFFFF, 5'd16}, 1'b1, 2'd0, 9'h000, 9'h000};
         4:  return '{'{CMD_ENCODE, 8'h41, 16'h0000, 5'd0},  1'b1, 2'd2, 9'h0FF, 9'h0FF};
         // stray code bits above the length
         5:  return '{'{CMD_LOAD,   8'hFF, 16'hFFFF, 5'd3},  1'b1, 2'd0, 9'h000, 9'h000};
         6:  return '{'{CMD_ENCODE, 8'hFF, 16'h0000, 5'd0},  1'b1, 2'd0, 9'h000, 9'h000};
         7:  return '{'{CMD_FLUSH,  8'h00, 16'h0000, 5'd0},  1'b1, 2'd1, 9'h107, 9'h000};
         // overlong length saturates
         8:  return '{'{CMD_LOAD,   8'h00, 16'hAAAA, 5'd31}, 1'b1, 2'd0, 9'h000, 9'h000};
         9:  return '{'{CMD_ENCODE, 8'h00, 16'h0000, 5'd0},  1'b1, 2'd2, 9'h0AA, 9'h0AA};
         10: return '{'{CMD_LOAD,   8'h10, 16'h0001, 5'd1},  1'b1, 2'd0, 9'h000, 9'h000};
         11: return '{'{CMD_ENCODE, 8'h10, 16'h0000, 5'd0},  1'b1, 2'd0, 9'h000, 9'h000};
         12: return '{'{CMD_ENCODE, 8'h00, 16'h0000, 5'd0},  1'b0, 2'd0, 9'h000, 9'h000};
         // reload as zero-length
         13: return '{'{CMD_LOAD,   8'h10, 16'hFFFF, 5'd0},  1'b1, 2'd0, 9'h000, 9'h000};
         14: return '{'{CMD_ENCODE, 8'h10, 16'h0000, 5'd0},  1'b1, 2'd0, 9'h000, 9'h000};
         15: return '{'{CMD_LOAD,   8'h80, 16'h0000, 5'd7},  1'b1, 2'd0, 9'h000, 9'h000};
         16: return '{'{CMD_ENCODE, 8'h80, 16'h0000, 5'd0},  1'b0, 2'd0, 9'h000, 9'h000};
         17: return '{'{CMD_LOAD,   8'h7F, 16'h7FFF, 5'd15}, 1'b1, 2'd0, 9'h000, 9'h000};
         18: return '{'{CMD_ENCODE, 8'h7F, 16'h0000, 5'd0},  1'b0, 2'd0, 9'h000, 9'h000};
         // 7 pending plus 16 code bits: fullest accumulator
         19: return '{'{CMD_ENCODE, 8'h41, 16'h0000, 5'd0},  1'b0, 2'd0, 9'h000, 9'h000};
         20: return '{'{CMD_FLUSH,  8'h00, 16'h0000, 5'd0},  1'b0, 2'd0, 9'h000, 9'h000};
         21: return '{'{CMD_UNUSED, 8'hFF, 16'hFFFF, 5'd31}, 1'b1, 2'd0, 9'h000, 9'h000};
         22: return '{'{CMD_LOAD,   8'h55, 16'h5555, 5'd17}, 1'b1, 2'd0, 9'h000, 9'h000};
         23: return '{'{CMD_ENCODE, 8'h55, 16'h0000, 5'd0},  1'b0, 2'd0, 9'h000, 9'h000};
         default: return '{'{CMD_FLUSH, 8'h00, 16'h0000, 5'd0}, 1'b0, 2'd0, 9'h000, 9'h000};
      endcase
   endfunction

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_sink
      int stall;
      bit long_hold;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         long_hold = hold_req;
         if (long_hold) stall = HOLD_CYCLES;
         else stall = no_idle ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         if (long_hold) begin
            held_cycles = stall;
            hold_req    = 1'b0;
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // compare every byte transfer with the oldest one due
   always @(posedge clock) begin
      out_entry_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_bytes.size() == 0) begin
            report_mismatch("byte with none due", {rsp_ch.last, rsp_ch.packed_byte}, '0);
         end else begin
            due = due_bytes.pop_front();
            if (rsp_ch.packed_byte !== due.packed_byte)
               report_mismatch("packed_byte", {1'b0, rsp_ch.packed_byte},
                               {1'b0, due.packed_byte});
            if (rsp_ch.last !== due.last)
               report_mismatch("last", {8'h00, rsp_ch.last}, {8'h00, due.last});
         end
         if (rsp_ch.last === 1'b1) tails_seen++;
         bytes_seen++;
      end
   end

   // reset, directed rows, random traffic, drain
   initial begin
      stim_row_type row;
      int           counted;
      int           pick;
      bit           hold_started;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.command     = CMD_LOAD;
      req_ch.symbol      = '0;
      req_ch.code_bits   = '0;
      req_ch.code_length = '0;
      for (int s = 0; s < 256; s++) begin
         code_tab[s] = '0;
         len_tab[s]  = '0;
      end
      acc_bits     = '0;
      acc_cnt      = '0;
      hold_started = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) send_request(directed_row(i));

      // random part: build a table first, then mostly encodes
      counted = 0;
      while (counted < N_RANDOM) begin
         pick = $urandom_range(0, 99);
         row  = '0;
         if (counted < 24) begin
            row.rq = '{CMD_LOAD, 8'(counted), 16'($urandom), 5'($urandom_range(1, 16))};
         end else if (pick < 8) begin
            row.rq = '{CMD_LOAD,
                       (pick < 3) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 31)),
                       16'($urandom), 5'($urandom_range(0, 31))};
         end else if (pick < 82) begin
            row.rq = '{CMD_ENCODE,
                       ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 31)),
                       16'($urandom), 5'($urandom)};
         end else if (pick < 96) begin
            row.rq = '{CMD_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom)};
         end else begin
            row.rq = '{CMD_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom)};
         end
         // long output hold-off while requests keep coming back to back
         if (counted == 60 && !hold_started) begin
            hold_req     = 1'b1;
            hold_started = 1'b1;
         end
         no_idle = (counted >= 120 && counted < 150);
         send_request(row);
         if (row.rq.command != CMD_UNUSED) counted++;
      end
      no_idle = 1'b0;
      req_ch.valid <= 1'b0;

      while (due_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads, %0d encodes, %0d flushes, %0d unused commands",
               n_loads, n_encodes, n_flushes, n_unused);
      $display("%0d bytes compared (%0d flush tails), output held off once for %0d cycles",
               bytes_seen, tails_seen, held_cycles);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/tdpc_pkg.sv
rtl/tdpc_channels.sv
rtl/table_driven_prefix_code_packer.sv
bench/table_driven_prefix_code_packer_tb.sv
